// ===== rtl/core/gasp_pkg.sv =====
// ----------------------------------------------------------------------------
// gasp_pkg
// shared types, codes and move tables of the grid path search block
// ----------------------------------------------------------------------------
package gasp_pkg;

    // cost words are 32 bits, saturating
    localparam int COST_W = 32;

    // action codes carried in tuser of the input stream
    localparam logic [1:0] ACT_MAP  = 2'd0;
    localparam logic [1:0] ACT_SRCH = 2'd1;
    localparam logic [1:0] ACT_STEP = 2'd2;

    // status codes carried in tuser of the output stream
    localparam logic [1:0] ST_FOUND  = 2'd0;
    localparam logic [1:0] ST_NOPATH = 2'd1;
    localparam logic [1:0] ST_OVFL   = 2'd2;
    localparam logic [1:0] ST_STEP   = 2'd3;

    // configuration register indexes
    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    // sequencer states
    typedef enum logic [22:0] {
        S_INIT  = 23'd1 << 0,
        S_IDLE  = 23'd1 << 1,
        S_CLR   = 23'd1 << 2,
        S_SRCH  = 23'd1 << 3,
        S_SPUSH = 23'd1 << 4,
        S_POPA  = 23'd1 << 5,
        S_POPB  = 23'd1 << 6,
        S_POPC  = 23'd1 << 7,
        S_SL    = 23'd1 << 8,
        S_SR    = 23'd1 << 9,
        S_SC    = 23'd1 << 10,
        S_VA    = 23'd1 << 11,
        S_VB    = 23'd1 << 12,
        S_EA    = 23'd1 << 13,
        S_EB    = 23'd1 << 14,
        S_EC    = 23'd1 << 15,
        S_PU    = 23'd1 << 16,
        S_PV    = 23'd1 << 17,
        S_TA    = 23'd1 << 18,
        S_TB    = 23'd1 << 19,
        S_RA    = 23'd1 << 20,
        S_RB    = 23'd1 << 21,
        S_EMIT  = 23'd1 << 22
    } t_state;

    // row offset of move direction d
    function automatic logic signed [1:0] mv_dr(input logic [2:0] d);
        case (d)
            3'd0, 3'd1, 3'd2: mv_dr = -2'sd1;
            3'd3, 3'd4:       mv_dr = 2'sd0;
            default:          mv_dr = 2'sd1;
        endcase
    endfunction

    // column offset of move direction d
    function automatic logic signed [1:0] mv_dc(input logic [2:0] d);
        case (d)
            3'd0, 3'd3, 3'd5: mv_dc = -2'sd1;
            3'd1, 3'd6:       mv_dc = 2'sd0;
            default:          mv_dc = 2'sd1;
        endcase
    endfunction

    // straight moves
    function automatic logic mv_straight(input logic [2:0] d);
        mv_straight = (d == 3'd1) || (d == 3'd3) || (d == 3'd4) || (d == 3'd6);
    endfunction

endpackage

// ===== rtl/core/grid_astar_path_search.sv =====
// ----------------------------------------------------------------------------
// grid_astar_path_search
// A* search on an 8-connected occupancy grid with octile heuristic
// ----------------------------------------------------------------------------
// Input stream: tuser carries the action (map write, search, path step),
// tdata the cell, start and goal fields. Output stream: tuser the status,
// tlast the start-cell flag, tdata the path length and path cell.
// Config channel: index 0 rows in use, index 1 columns in use, taken at once.
// A map write is done when taken and gives no word. A search first sweeps
// the cost store, one cell a cycle (MAX_ROWS*MAX_COLS rounded up to a power
// of two of each side), then pops and expands cells through one heap port
// and one cost store port: a pop reads top and last and sifts down by left
// child, right child and choice, a push sifts up by parent, each neighbour
// has cost and map read before its push, and the length count walks back
// the path. A path step reads the cost store. The block takes one item at a time.
// After reset a sweep of the same length clears map and cost store, with the
// input held off. A stalled receiver holds the finished word in the output
// register; the block then waits before handing on the next result.
// ----------------------------------------------------------------------------
module grid_astar_path_search import gasp_pkg::*; #(
    parameter int MAX_ROWS       = 64,
    parameter int MAX_COLS       = 64,
    parameter int HEAP_DEPTH     = 4096,
    parameter int COST_FRAC_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // action
    input  logic [1:0]  i_s_tuser,
    // cell_row, cell_col, cell_blocked, start_row, start_col, goal_row, goal_col
    input  logic [39:0] i_s_tdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // status
    output logic [1:0]  o_m_tuser,
    // path_length, step_row, step_col
    output logic [31:0] o_m_tdata,
    output logic        o_m_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [6:0]  i_cfg_data
);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int AW    = RW + CW;
    localparam int HW    = $clog2(HEAP_DEPTH);
    localparam int KW    = COST_W + AW;
    localparam int NW    = COST_W + 4;
    localparam int LW    = AW + 1;
    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam logic [COST_W-1:0] COST_ONE = COST_W'(1) << COST_FRAC_BITS;
    localparam logic [COST_W-1:0] COST_DIAG = COST_W'(
        ((64'd141421356 << COST_FRAC_BITS) + 64'd50000000) / 64'd100000000);
    localparam logic [NW-1:0] NODE_CLR = {4'b0000, {COST_W{1'b1}}};

    // moved row, forwards or backwards along direction d
    function automatic logic signed [RW+1:0] f_mrow(input logic [RW-1:0] row,
                                                   input logic [2:0] d,
                                                   input logic back);
        logic signed [RW+1:0] off;
        off = (RW+2)'(mv_dr(d));
        f_mrow = back ? $signed({2'b00, row}) - off : $signed({2'b00, row}) + off;
    endfunction

    // moved column, forwards or backwards along direction d
    function automatic logic signed [CW+1:0] f_mcol(input logic [CW-1:0] col,
                                                   input logic [2:0] d,
                                                   input logic back);
        logic signed [CW+1:0] off;
        off = (CW+2)'(mv_dc(d));
        f_mcol = back ? $signed({2'b00, col}) - off : $signed({2'b00, col}) + off;
    endfunction

    // input fields
    logic [1:0] f_act;
    logic [5:0] f_crow, f_ccol, f_srow, f_scol, f_grow, f_gcol;
    logic       f_cblk;
    assign f_act  = i_s_tuser;
    assign f_crow = i_s_tdata[5:0];
    assign f_ccol = i_s_tdata[11:6];
    assign f_cblk = i_s_tdata[12];
    assign f_srow = i_s_tdata[18:13];
    assign f_scol = i_s_tdata[24:19];
    assign f_grow = i_s_tdata[30:25];
    assign f_gcol = i_s_tdata[36:31];

    // control registers
    t_state          r_state, n_state;
    logic [6:0]      r_rows, r_cols;
    logic [HW:0]     r_cnt, n_cnt;
    logic            r_ready, n_ready;
    logic            r_ov, n_ov;
    // payload registers
    logic [AW-1:0]   r_clr, n_clr;
    logic [RW-1:0]   r_sr, n_sr, r_gr, n_gr;
    logic [CW-1:0]   r_sc, n_sc, r_gc, n_gc;
    logic            r_ok, n_ok;
    logic [KW-1:0]   r_top, n_top, r_last, n_last, r_left, n_left, r_item, n_item;
    logic [HW-1:0]   r_i, n_i;
    logic [COST_W-1:0] r_gcur, n_gcur, r_g, n_g;
    logic            r_nvis, n_nvis;
    logic [2:0]      r_d, n_d;
    logic [AW-1:0]   r_t, n_t, r_cur, n_cur, r_pcur, n_pcur, r_pstart, n_pstart;
    logic [LW-1:0]   r_n, n_n, r_len, n_len;
    logic [1:0]      r_rs, n_rs;
    logic [12:0]     r_rl, n_rl;
    logic [5:0]      r_rr, n_rr, r_rc, n_rc;
    logic            r_rlast, n_rlast;
    logic [1:0]      r_os, n_os;
    logic [12:0]     r_ol, n_ol;
    logic [5:0]      r_orow, n_orow, r_ocol, n_ocol;
    logic            r_olast, n_olast;

    // memory ports
    logic            ob_we, ob_wd, ob_rd;
    logic [AW-1:0]   ob_wa, ob_ra;
    logic            nd_we;
    logic [AW-1:0]   nd_wa, nd_ra;
    logic [NW-1:0]   nd_wd, nd_rd;
    logic            hp_we;
    logic [HW-1:0]   hp_wa, hp_ra;
    logic [KW-1:0]   hp_wd, hp_rd;

    // memories
    logic            mem_ob [2**AW];
    logic [NW-1:0]   mem_nd [2**AW];
    logic [KW-1:0]   mem_hp [2**HW];

    always_ff @(posedge i_clk) begin
        if (ob_we) begin
            mem_ob[ob_wa] <= ob_wd;
        end
        ob_rd <= mem_ob[ob_ra];
    end

    always_ff @(posedge i_clk) begin
        if (nd_we) begin
            mem_nd[nd_wa] <= nd_wd;
        end
        nd_rd <= mem_nd[nd_ra];
    end

    always_ff @(posedge i_clk) begin
        if (hp_we) begin
            mem_hp[hp_wa] <= hp_wd;
        end
        hp_rd <= mem_hp[hp_ra];
    end

    // grid size in use, clamped
    logic [RW:0] eff_rows;
    logic [CW:0] eff_cols;
    always_comb begin
        if (r_rows == '0) begin
            eff_rows = (RW+1)'(1);
        end else if (32'(r_rows) > MAX_ROWS) begin
            eff_rows = (RW+1)'(MAX_ROWS);
        end else begin
            eff_rows = (RW+1)'(r_rows);
        end
        if (r_cols == '0) begin
            eff_cols = (CW+1)'(1);
        end else if (32'(r_cols) > MAX_COLS) begin
            eff_cols = (CW+1)'(MAX_COLS);
        end else begin
            eff_cols = (CW+1)'(r_cols);
        end
    end

    // shared octile unit
    logic              oc_en;
    logic [RW-1:0]     oc_r;
    logic [CW-1:0]     oc_c;
    logic [COST_W-1:0] oc_h;

    gasp_octile #(
        .RW        (RW),
        .CW        (CW),
        .FRAC_BITS (COST_FRAC_BITS)
    ) u_octile (
        .i_clk (i_clk),
        .i_en  (oc_en),
        .i_ar  (oc_r),
        .i_ac  (oc_c),
        .i_br  (r_gr),
        .i_bc  (r_gc),
        .o_h   (oc_h)
    );

    // neighbour, sift and trace helpers
    logic signed [RW+1:0] tr, pr;
    logic signed [CW+1:0] tc, pc;
    logic          t_in, p_in;
    logic [HW:0]   sl_l, sl_r;
    logic [HW-1:0] pu_p;
    logic [COST_W:0] g_sum, f_sum;
    logic [COST_W-1:0] g_new, f_new;
    logic [AW-1:0] a_start, a_goal;
    logic          load_out;

    always_comb begin
        tr   = f_mrow(r_top[AW-1:CW], r_d, 1'b0);
        tc   = f_mcol(r_top[CW-1:0], r_d, 1'b0);
        t_in = !tr[RW+1] && (tr[RW:0] < eff_rows) && !tc[CW+1] && (tc[CW:0] < eff_cols);
        pr   = f_mrow((r_state == S_RB) ? r_pcur[AW-1:CW] : r_cur[AW-1:CW],
                      nd_rd[COST_W+2:COST_W], 1'b1);
        pc   = f_mcol((r_state == S_RB) ? r_pcur[CW-1:0] : r_cur[CW-1:0],
                      nd_rd[COST_W+2:COST_W], 1'b1);
        p_in = !pr[RW+1] && (pr[RW:0] < (RW+1)'(MAX_ROWS))
            && !pc[CW+1] && (pc[CW:0] < (CW+1)'(MAX_COLS));
        sl_l = {r_i, 1'b1};
        sl_r = sl_l + (HW+1)'(1);
        pu_p = (r_i - HW'(1)) >> 1;
        g_sum = {1'b0, r_gcur} + {1'b0, mv_straight(r_d) ? COST_ONE : COST_DIAG};
        g_new = g_sum[COST_W] ? '1 : g_sum[COST_W-1:0];
        f_sum = {1'b0, r_g} + {1'b0, oc_h};
        f_new = f_sum[COST_W] ? '1 : f_sum[COST_W-1:0];
        a_start = {r_sr, r_sc};
        a_goal  = {r_gr, r_gc};
    end

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign load_out    = (r_state == S_EMIT) && (!r_ov || i_m_tready);

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;   n_ready = r_ready; n_ov = r_ov;
        n_clr = r_clr;   n_sr = r_sr;  n_sc = r_sc;  n_gr = r_gr;  n_gc = r_gc;
        n_ok = r_ok;     n_top = r_top; n_last = r_last; n_left = r_left;
        n_item = r_item; n_i = r_i;    n_gcur = r_gcur; n_g = r_g; n_nvis = r_nvis;
        n_d = r_d;       n_t = r_t;    n_cur = r_cur; n_pcur = r_pcur;
        n_pstart = r_pstart; n_n = r_n; n_len = r_len;
        n_rs = r_rs; n_rl = r_rl; n_rr = r_rr; n_rc = r_rc; n_rlast = r_rlast;
        n_os = r_os; n_ol = r_ol; n_orow = r_orow; n_ocol = r_ocol; n_olast = r_olast;
        ob_we = 1'b0; ob_wa = '0; ob_wd = 1'b0; ob_ra = '0;
        nd_we = 1'b0; nd_wa = '0; nd_wd = NODE_CLR; nd_ra = '0;
        hp_we = 1'b0; hp_wa = '0; hp_wd = r_item; hp_ra = '0;
        oc_en = 1'b0; oc_r = r_sr; oc_c = r_sc;

        // output register drains
        if (r_ov && i_m_tready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            // clear map and cost store after reset
            S_INIT: begin
                ob_we = 1'b1; ob_wa = r_clr; ob_wd = 1'b0;
                nd_we = 1'b1; nd_wa = r_clr; nd_wd = NODE_CLR;
                n_clr = r_clr + AW'(1);
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    case (f_act)
                        ACT_MAP: begin
                            if (32'(f_crow) < MAX_ROWS && 32'(f_ccol) < MAX_COLS) begin
                                ob_we = 1'b1;
                                ob_wa = {RW'(f_crow), CW'(f_ccol)};
                                ob_wd = f_cblk;
                            end
                        end
                        ACT_SRCH: begin
                            n_sr = RW'(f_srow); n_sc = CW'(f_scol);
                            n_gr = RW'(f_grow); n_gc = CW'(f_gcol);
                            n_ok = (32'(f_srow) < 32'(eff_rows)) && (32'(f_scol) < 32'(eff_cols))
                                && (32'(f_grow) < 32'(eff_rows)) && (32'(f_gcol) < 32'(eff_cols));
                            n_ready = 1'b0;
                            n_cnt = '0;
                            n_clr = '0;
                            n_state = S_CLR;
                        end
                        ACT_STEP: begin
                            if (r_ready) begin
                                n_state = S_RA;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // per-search sweep of costs and visited marks
            S_CLR: begin
                nd_we = 1'b1; nd_wa = r_clr; nd_wd = NODE_CLR;
                n_clr = r_clr + AW'(1);
                if (r_clr == '1) begin
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                if (!r_ok) begin
                    n_rs = ST_NOPATH; n_rl = '0; n_rr = '0; n_rc = '0; n_rlast = 1'b0;
                    n_state = S_EMIT;
                end else begin
                    nd_we = 1'b1; nd_wa = a_start; nd_wd = '0;
                    oc_en = 1'b1;
                    n_state = S_SPUSH;
                end
            end
            S_SPUSH: begin
                hp_we = 1'b1; hp_wa = '0; hp_wd = {oc_h, a_start};
                n_cnt = (HW+1)'(1);
                n_state = S_POPA;
            end
            // pop: read the top, then the last entry
            S_POPA: begin
                if (r_cnt == '0) begin
                    n_rs = ST_NOPATH; n_rl = '0; n_rr = '0; n_rc = '0; n_rlast = 1'b0;
                    n_state = S_EMIT;
                end else begin
                    hp_ra = '0;
                    n_cnt = r_cnt - (HW+1)'(1);
                    n_state = S_POPB;
                end
            end
            S_POPB: begin
                n_top = hp_rd;
                if (r_cnt == '0) begin
                    n_state = S_VA;
                end else begin
                    hp_ra = r_cnt[HW-1:0];
                    n_state = S_POPC;
                end
            end
            S_POPC: begin
                n_last = hp_rd;
                n_i = '0;
                n_state = S_SL;
            end
            // sift down: left child, right child, choose
            S_SL: begin
                if (sl_l >= r_cnt) begin
                    hp_we = 1'b1; hp_wa = r_i; hp_wd = r_last;
                    n_state = S_VA;
                end else begin
                    hp_ra = sl_l[HW-1:0];
                    n_state = S_SR;
                end
            end
            S_SR: begin
                n_left = hp_rd;
                if (sl_r < r_cnt) begin
                    hp_ra = sl_r[HW-1:0];
                    n_state = S_SC;
                end else if (hp_rd < r_last) begin
                    hp_we = 1'b1; hp_wa = r_i; hp_wd = hp_rd;
                    n_i = sl_l[HW-1:0];
                    n_state = S_SL;
                end else begin
                    hp_we = 1'b1; hp_wa = r_i; hp_wd = r_last;
                    n_state = S_VA;
                end
            end
            S_SC: begin
                hp_we = 1'b1; hp_wa = r_i;
                if (r_left < r_last && !(hp_rd < r_left)) begin
                    hp_wd = r_left;
                    n_i = sl_l[HW-1:0];
                    n_state = S_SL;
                end else if (hp_rd < r_last) begin
                    hp_wd = hp_rd;
                    n_i = sl_r[HW-1:0];
                    n_state = S_SL;
                end else begin
                    hp_wd = r_last;
                    n_state = S_VA;
                end
            end
            // visit the popped cell
            S_VA: begin
                nd_ra = r_top[AW-1:0];
                n_state = S_VB;
            end
            S_VB: begin
                if (nd_rd[NW-1]) begin
                    n_state = S_POPA;
                end else begin
                    nd_we = 1'b1; nd_wa = r_top[AW-1:0]; nd_wd = {1'b1, nd_rd[NW-2:0]};
                    n_gcur = nd_rd[COST_W-1:0];
                    if (r_top[AW-1:0] == a_goal) begin
                        n_cur = a_goal; n_pcur = a_goal; n_pstart = a_start;
                        n_n = LW'(1);
                        n_state = S_TA;
                    end else begin
                        n_d = '0;
                        n_state = S_EA;
                    end
                end
            end
            // neighbour: read cost and map, start heuristic
            S_EA: begin
                if (!t_in) begin
                    n_d = r_d + 3'd1;
                    n_state = (r_d == 3'd7) ? S_POPA : S_EA;
                end else begin
                    nd_ra = {tr[RW-1:0], tc[CW-1:0]};
                    ob_ra = {tr[RW-1:0], tc[CW-1:0]};
                    n_t = {tr[RW-1:0], tc[CW-1:0]};
                    oc_en = 1'b1; oc_r = tr[RW-1:0]; oc_c = tc[CW-1:0];
                    n_state = S_EB;
                end
            end
            S_EB: begin
                n_g = g_new;
                n_nvis = nd_rd[NW-1];
                if (ob_rd || !(g_new < nd_rd[COST_W-1:0])) begin
                    n_d = r_d + 3'd1;
                    n_state = (r_d == 3'd7) ? S_POPA : S_EA;
                end else begin
                    n_state = S_EC;
                end
            end
            // relax and start the push
            S_EC: begin
                nd_we = 1'b1; nd_wa = r_t; nd_wd = {r_nvis, r_d, r_g};
                if (32'(r_cnt) >= HEAP_DEPTH) begin
                    n_rs = ST_OVFL; n_rl = '0; n_rr = '0; n_rc = '0; n_rlast = 1'b0;
                    n_state = S_EMIT;
                end else begin
                    n_item = {f_new, r_t};
                    n_i = r_cnt[HW-1:0];
                    n_cnt = r_cnt + (HW+1)'(1);
                    n_state = S_PU;
                end
            end
            // sift up
            S_PU: begin
                if (r_i == '0) begin
                    hp_we = 1'b1; hp_wa = '0; hp_wd = r_item;
                    n_d = r_d + 3'd1;
                    n_state = (r_d == 3'd7) ? S_POPA : S_EA;
                end else begin
                    hp_ra = pu_p;
                    n_state = S_PV;
                end
            end
            S_PV: begin
                hp_we = 1'b1; hp_wa = r_i;
                if (r_item < hp_rd) begin
                    hp_wd = hp_rd;
                    n_i = pu_p;
                    n_state = S_PU;
                end else begin
                    hp_wd = r_item;
                    n_d = r_d + 3'd1;
                    n_state = (r_d == 3'd7) ? S_POPA : S_EA;
                end
            end
            // count path cells back to the start
            S_TA: begin
                if (r_cur == a_start || 32'(r_n) >= CELLS) begin
                    n_len = r_n; n_ready = 1'b1;
                    n_rs = ST_FOUND; n_rl = 13'(r_n); n_rr = '0; n_rc = '0; n_rlast = 1'b0;
                    n_state = S_EMIT;
                end else begin
                    nd_ra = r_cur;
                    n_state = S_TB;
                end
            end
            S_TB: begin
                if (!p_in) begin
                    n_len = r_n; n_ready = 1'b1;
                    n_rs = ST_FOUND; n_rl = 13'(r_n); n_rr = '0; n_rc = '0; n_rlast = 1'b0;
                    n_state = S_EMIT;
                end else begin
                    n_cur = {pr[RW-1:0], pc[CW-1:0]};
                    n_n = r_n + LW'(1);
                    n_state = S_TA;
                end
            end
            // path step readout
            S_RA: begin
                nd_ra = r_pcur;
                n_state = S_RB;
            end
            S_RB: begin
                n_rs = ST_STEP; n_rl = 13'(r_len);
                n_rr = 6'(r_pcur[AW-1:CW]); n_rc = 6'(r_pcur[CW-1:0]);
                n_rlast = (r_pcur == r_pstart);
                if (r_pcur == r_pstart || !p_in) begin
                    n_ready = 1'b0;
                end else begin
                    n_pcur = {pr[RW-1:0], pc[CW-1:0]};
                end
                n_state = S_EMIT;
            end
            // hand the word to the output register
            S_EMIT: begin
                if (load_out) begin
                    n_ov = 1'b1;
                    n_os = r_rs; n_ol = r_rl; n_orow = r_rr; n_ocol = r_rc;
                    n_olast = r_rlast;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_rows  <= 7'd64;
            r_cols  <= 7'd64;
            r_cnt   <= '0;
            r_ready <= 1'b0;
            r_ov    <= 1'b0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ready <= n_ready;
            r_ov    <= n_ov;
            r_clr   <= n_clr;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_ROWS: r_rows <= i_cfg_data;
                    CFG_COLS: r_cols <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_sr <= n_sr; r_sc <= n_sc; r_gr <= n_gr; r_gc <= n_gc; r_ok <= n_ok;
        r_top <= n_top; r_last <= n_last; r_left <= n_left; r_item <= n_item;
        r_i <= n_i; r_gcur <= n_gcur; r_g <= n_g; r_nvis <= n_nvis; r_d <= n_d;
        r_t <= n_t; r_cur <= n_cur; r_pcur <= n_pcur; r_pstart <= n_pstart;
        r_n <= n_n; r_len <= n_len;
        r_rs <= n_rs; r_rl <= n_rl; r_rr <= n_rr; r_rc <= n_rc; r_rlast <= n_rlast;
        r_os <= n_os; r_ol <= n_ol; r_orow <= n_orow; r_ocol <= n_ocol;
        r_olast <= n_olast;
    end

    // output word
    assign o_m_tvalid = r_ov;
    assign o_m_tuser  = r_os;
    assign o_m_tlast  = r_olast;
    assign o_m_tdata  = {7'b0, r_ocol, r_orow, r_ol};

    // heap never holds more than its depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= HEAP_DEPTH)
        else $error("heap count above depth");

    // a found status leaves a path ready to read
    a_found_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && r_rs == ST_FOUND) |=> r_ready)
        else $error("found without path");

    // sift up never compares the root with a parent
    a_pv_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PV) |-> (r_i != '0))
        else $error("sift up past root");

    // a result word is never loaded over one still waiting
    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_m_tready) |-> !load_out)
        else $error("output word overwritten");

endmodule

// ===== rtl/core/gasp_octile.sv =====
// ----------------------------------------------------------------------------
// gasp_octile
// registered octile distance between two cells, fixed point
// ----------------------------------------------------------------------------
module gasp_octile import gasp_pkg::*; #(
    parameter int RW        = 6,
    parameter int CW        = 6,
    parameter int FRAC_BITS = 12
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [RW-1:0]     i_ar,
    input  logic [CW-1:0]     i_ac,
    input  logic [RW-1:0]     i_br,
    input  logic [CW-1:0]     i_bc,
    output logic [COST_W-1:0] o_h
);
    localparam int DW = (RW > CW) ? RW : CW;
    localparam int PW = DW + FRAC_BITS + 3;
    localparam longint DIAG_L =
        ((64'd141421356 << FRAC_BITS) + 64'd50000000) / 64'd100000000;

    logic [DW-1:0]   dr, dc, mn, mx;
    logic [PW-1:0]   sum;
    logic [COST_W-1:0] r_h;

    // absolute differences, then min and max
    always_comb begin
        dr  = (i_ar > i_br) ? DW'(i_ar - i_br) : DW'(i_br - i_ar);
        dc  = (i_ac > i_bc) ? DW'(i_ac - i_bc) : DW'(i_bc - i_ac);
        mn  = (dr < dc) ? dr : dc;
        mx  = (dr < dc) ? dc : dr;
        sum = (PW'(mx - mn) << FRAC_BITS) + PW'(mn) * PW'(DIAG_L);
    end

    // saturate into the cost word
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (PW > COST_W && (sum >> COST_W) != '0) begin
                r_h <= '1;
            end else begin
                r_h <= COST_W'(sum);
            end
        end
    end

    assign o_h = r_h;

endmodule

// ===== sim/tb_grid_astar_path_search.sv =====
// ----------------------------------------------------------------------------
// tb_grid_astar_path_search
// self-checking bench for the grid A* path search block
// ----------------------------------------------------------------------------
// Drives map writes, searches and path reads on the input stream and checks
// every output word against a behavioural A* planner kept in the bench or a
// fixed expected word. A directed table is followed by randomised phases
// at several grid sizes. Both stream sides idle at random, and the receiver
// stalls once for a long stretch.
// ----------------------------------------------------------------------------
module tb_grid_astar_path_search;
    import gasp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCELL     = 4096;
    localparam int GCOLS     = 64;
    localparam int HEAP_N    = 4096;
    localparam int STEP_1    = 4096;
    localparam int STEP_D    = 5793;
    localparam int WDOG_MAX  = 10000000;
    localparam logic [1:0] ACT_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]  st;
        logic [12:0] len;
        logic [5:0]  row;
        logic [5:0]  col;
        logic        last;
    } route_word_t;

    typedef struct {
        logic [1:0]  act;
        logic [39:0] data;
        bit          fixed;
        route_word_t want;
    } drill_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic [1:0]  i_s_tuser = ACT_MAP;
    logic [39:0] i_s_tdata = '0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [1:0]  o_m_tuser;
    logic [31:0] o_m_tdata;
    logic        o_m_tlast;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b1;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = CFG_ROWS;
    logic [6:0]  i_cfg_data = '0;

    grid_astar_path_search dut (.*);

    // planner state
    bit          m_blk [NCELL];
    logic [31:0] m_g   [NCELL];
    bit          m_vis [NCELL];
    logic [2:0]  m_par [NCELL];
    logic [31:0] h_f [HEAP_N];
    int          h_r [HEAP_N];
    int          h_c [HEAP_N];
    int          h_n;
    int          m_rows = 64, m_cols = 64;
    bit          p_ready;
    int          p_cur, p_len, p_start;
    int          mv_r [8] = '{-1, -1, -1, 0, 0, 1, 1, 1};
    int          mv_c [8] = '{-1, 0, 1, -1, 1, -1, 0, 1};

    route_word_t pending_words [$];
    drill_row_t  drill [$];
    int          n_err, n_found, n_nopath, n_ovfl, n_steps, n_cfg, n_items;
    int          send_idle = 0, recv_idle = 0, rx_hold = 0, idle_cyc = 0;
    bit          rand_on;

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [39:0] pack_in(int cr, int cc, int cb, int sr, int sc,
                                            int gr, int gc);
        return {3'b0, 6'(gc), 6'(gr), 6'(sc), 6'(sr), 1'(cb), 6'(cc), 6'(cr)};
    endfunction

    function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + b;
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [31:0] octile_h(int r1, int c1, int r2, int c2);
        int dr, dc, mn, mx;
        dr = r1 > r2 ? r1 - r2 : r2 - r1;
        dc = c1 > c2 ? c1 - c2 : c2 - c1;
        mn = dr < dc ? dr : dc;
        mx = dr < dc ? dc : dr;
        return 32'((mx - mn) * STEP_1 + mn * STEP_D);
    endfunction

    function automatic bit open_less(logic [31:0] fa, int ra, int ca,
                                     logic [31:0] fb, int rb, int cb);
        if (fa != fb) return fa < fb;
        if (ra != rb) return ra < rb;
        return ca < cb;
    endfunction

    function automatic bit open_push(logic [31:0] f, int r, int c);
        int i, p;
        if (h_n >= HEAP_N) return 1'b0;
        i = h_n;
        h_n++;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (!open_less(f, r, c, h_f[p], h_r[p], h_c[p])) break;
            h_f[i] = h_f[p]; h_r[i] = h_r[p]; h_c[i] = h_c[p];
            i = p;
        end
        h_f[i] = f; h_r[i] = r; h_c[i] = c;
        return 1'b1;
    endfunction

    function automatic void open_pop(output int r, output int c);
        logic [31:0] lf;
        int lr, lc, i, l, m;
        r = h_r[0];
        c = h_c[0];
        h_n--;
        if (h_n == 0) return;
        lf = h_f[h_n]; lr = h_r[h_n]; lc = h_c[h_n];
        i = 0;
        forever begin
            l = 2 * i + 1;
            m = i;
            if (l < h_n && open_less(h_f[l], h_r[l], h_c[l], lf, lr, lc)) m = l;
            if (l + 1 < h_n && (m == l ?
                    open_less(h_f[l+1], h_r[l+1], h_c[l+1], h_f[l], h_r[l], h_c[l]) :
                    open_less(h_f[l+1], h_r[l+1], h_c[l+1], lf, lr, lc)))
                m = l + 1;
            if (m == i) break;
            h_f[i] = h_f[m]; h_r[i] = h_r[m]; h_c[i] = h_c[m];
            i = m;
        end
        h_f[i] = lf; h_r[i] = lr; h_c[i] = lc;
    endfunction

    function automatic int eff_size(int raw);
        return raw == 0 ? 1 : (raw > 64 ? 64 : raw);
    endfunction

    // A* over the planner map, returns the status code
    function automatic logic [1:0] plan_route(int sr, int sc, int gr, int gc);
        int rows, cols, r, c, idx, tr, tc, t, cur, n, pr, pc;
        logic [31:0] g;
        rows = eff_size(m_rows);
        cols = eff_size(m_cols);
        foreach (m_vis[i]) begin
            m_vis[i] = 1'b0;
            m_g[i] = '1;
        end
        h_n = 0; p_ready = 0; p_len = 0; p_cur = 0;
        if (sr >= rows || sc >= cols || gr >= rows || gc >= cols) return ST_NOPATH;
        m_g[sr * GCOLS + sc] = 0;
        void'(open_push(octile_h(sr, sc, gr, gc), sr, sc));
        while (h_n > 0) begin
            open_pop(r, c);
            idx = r * GCOLS + c;
            if (m_vis[idx]) continue;
            m_vis[idx] = 1'b1;
            if (r == gr && c == gc) begin
                p_start = sr * GCOLS + sc;
                cur = idx;
                p_cur = cur;
                n = 1;
                while (cur != p_start && n < NCELL) begin
                    pr = cur / GCOLS - mv_r[m_par[cur]];
                    pc = cur % GCOLS - mv_c[m_par[cur]];
                    if (pr < 0 || pc < 0 || pr >= 64 || pc >= 64) break;
                    cur = pr * GCOLS + pc;
                    n++;
                end
                p_len = n;
                p_ready = 1'b1;
                return ST_FOUND;
            end
            for (int d = 0; d < 8; d++) begin
                tr = r + mv_r[d];
                tc = c + mv_c[d];
                if (tr < 0 || tc < 0 || tr >= rows || tc >= cols) continue;
                t = tr * GCOLS + tc;
                if (m_blk[t]) continue;
                g = sat_sum(m_g[idx], (mv_r[d] == 0 || mv_c[d] == 0) ? STEP_1 : STEP_D);
                if (g < m_g[t]) begin
                    m_g[t] = g;
                    m_par[t] = 3'(d);
                    if (!open_push(sat_sum(g, octile_h(tr, tc, gr, gc)), tr, tc))
                        return ST_OVFL;
                end
            end
        end
        return ST_NOPATH;
    endfunction

    // expected reaction to one accepted word
    function automatic bit predict_word(logic [1:0] act, logic [39:0] d,
                                        output route_word_t res);
        int pr, pc;
        res = '0;
        case (act)
            ACT_MAP: begin
                m_blk[d[5:0] * GCOLS + d[11:6]] = d[12];
                return 1'b0;
            end
            ACT_SRCH: begin
                res.st = plan_route(d[18:13], d[24:19], d[30:25], d[36:31]);
                res.len = res.st == ST_FOUND ? 13'(p_len) : 13'd0;
                return 1'b1;
            end
            ACT_STEP: begin
                if (!p_ready) return 1'b0;
                res.st = ST_STEP;
                res.len = 13'(p_len);
                res.row = 6'(p_cur / GCOLS);
                res.col = 6'(p_cur % GCOLS);
                res.last = p_cur == p_start;
                if (res.last) begin
                    p_ready = 1'b0;
                end else begin
                    pr = p_cur / GCOLS - mv_r[m_par[p_cur]];
                    pc = p_cur % GCOLS - mv_c[m_par[p_cur]];
                    if (pr < 0 || pc < 0 || pr >= 64 || pc >= 64) p_ready = 1'b0;
                    else p_cur = pr * GCOLS + pc;
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // offer one input word and record what it should produce
    task automatic put_word(input logic [1:0] act, input logic [39:0] d,
                            input bit fixed = 0, input route_word_t want = '0);
        route_word_t res;
        if (rand_on) begin
            send_idle = n_items < 233 ? 28 : (n_items < 466 ? 65 : 0);
            recv_idle = n_items < 233 ? 65 : (n_items < 466 ? 28 : 0);
        end
        if ($urandom_range(99) < send_idle) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= act;
        i_s_tdata <= d;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        if (act != ACT_NONE) n_items++;
        if (predict_word(act, d, res)) begin
            if (fixed) res = want;
            pending_words = {pending_words, res};
            case (res.st)
                ST_FOUND:  n_found++;
                ST_NOPATH: n_nopath++;
                ST_OVFL:   n_ovfl++;
                default:   n_steps++;
            endcase
        end
    endtask

    // sender pauses until every expected word is back
    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [6:0] val);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_ROWS) m_rows = val;
        else m_cols = val;
        n_cfg++;
    endtask

    // random sequences: map edits, a search, then the path read back
    task automatic run_phase(input int raw_r, input int raw_c, input int n_seq,
                             input int hold_at);
        int er, ec, sr, sc, gr, gc, rd;
        bit big;
        write_cfg(CFG_ROWS, 7'(raw_r));
        write_cfg(CFG_COLS, 7'(raw_c));
        er = eff_size(raw_r);
        ec = eff_size(raw_c);
        big = er * ec > 600;
        for (int s = 0; s < n_seq; s++) begin
            if (s == hold_at) rx_hold = 400;
            // leftover path from before, read after map or size changes
            if (p_ready && $urandom_range(1))
                repeat (2) put_word(ACT_STEP, 40'($urandom()));
            repeat ($urandom_range(0, big ? 2 : 5)) begin
                if ($urandom_range(9) == 0)
                    put_word(ACT_MAP, pack_in($urandom_range(63), $urandom_range(63),
                             $urandom_range(9) < 3, $urandom_range(63), $urandom_range(63),
                             $urandom_range(63), $urandom_range(63)));
                else
                    put_word(ACT_MAP, pack_in($urandom_range(er - 1), $urandom_range(ec - 1),
                             $urandom_range(9) < (big ? 1 : 3), $urandom_range(63),
                             $urandom_range(63), $urandom_range(63), $urandom_range(63)));
            end
            if ($urandom_range(15) == 0)
                put_word(ACT_NONE, {3'b0, 37'({$urandom(), $urandom()})});
            sr = $urandom_range(er - 1);
            sc = $urandom_range(ec - 1);
            if (big) begin
                gr = sr + $urandom_range(16) - 8;
                gc = sc + $urandom_range(16) - 8;
                gr = gr < 0 ? 0 : (gr >= er ? er - 1 : gr);
                gc = gc < 0 ? 0 : (gc >= ec ? ec - 1 : gc);
                // keep large-grid searches short: goal always open
                if (m_blk[gr * GCOLS + gc])
                    put_word(ACT_MAP, pack_in(gr, gc, 0, 0, 0, 0, 0));
            end else begin
                gr = $urandom_range(er - 1);
                gc = $urandom_range(ec - 1);
                if ($urandom_range(9) == 0) begin
                    sr = $urandom_range(63);
                    gc = $urandom_range(63);
                end
                if ($urandom_range(19) == 0) begin
                    gr = sr;
                    gc = sc;
                end
            end
            put_word(ACT_SRCH, pack_in($urandom_range(63), $urandom_range(63),
                     $urandom_range(1), sr, sc, gr, gc));
            rd = p_ready ? p_len + $urandom_range(2) : $urandom_range(1);
            for (int k = 0; k < rd; k++) begin
                if ($urandom_range(9) == 0) break;
                if ($urandom_range(11) == 0)
                    put_word(ACT_MAP, pack_in($urandom_range(er - 1),
                             $urandom_range(ec - 1), $urandom_range(1), 0, 0, 0, 0));
                put_word(ACT_STEP, 40'({$urandom(), $urandom()}));
            end
        end
    endtask

    function automatic drill_row_t mk_row(logic [1:0] act, logic [39:0] d, bit fixed = 0,
                                          logic [1:0] st = 0, int len = 0, int r = 0,
                                          int c = 0, bit last = 0);
        drill_row_t x;
        x.act = act;
        x.data = d;
        x.fixed = fixed;
        x.want = '{st: st, len: 13'(len), row: 6'(r), col: 6'(c), last: last};
        return x;
    endfunction

    // append one row to the directed table
    function automatic void add_row(drill_row_t x);
        drill = {drill, x};
    endfunction

    // output side: check each word, then choose the next ready
    always @(posedge i_clk) begin
        route_word_t w;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word status %0d tdata %h last %b",
                         $realtime, o_m_tuser, o_m_tdata, o_m_tlast);
                n_err++;
            end else begin
                w = pending_words.pop_front();
                if (o_m_tuser !== w.st || o_m_tdata !== {7'b0, w.col, w.row, w.len} ||
                        o_m_tlast !== w.last) begin
                    $display("%0t: mismatch expected st %0d len %0d cell (%0d,%0d) last %b",
                             $realtime, w.st, w.len, w.row, w.col, w.last);
                    $display("%0t:          actual   st %0d len %0d cell (%0d,%0d) last %b",
                             $realtime, o_m_tuser, o_m_tdata[12:0], o_m_tdata[18:13],
                             o_m_tdata[24:19], o_m_tlast);
                    n_err++;
                end
            end
        end
        if (rx_hold > 0) begin
            rx_hold--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= $urandom_range(99) >= recv_idle;
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
            idle_cyc <= 0;
        end else if (idle_cyc >= WDOG_MAX) begin
            $display("%0t: no progress, timed out", $realtime);
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cyc <= idle_cyc + 1;
        end
    end

    // stimulus
    initial begin
        foreach (m_blk[i]) begin
            m_blk[i] = 1'b0;
            m_par[i] = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part on the full 64x64 grid
        send_idle = 20;
        recv_idle = 20;
        add_row(mk_row(ACT_STEP, '0));
        add_row(mk_row(ACT_SRCH, pack_in(0, 0, 0, 0, 0, 0, 0), 1, ST_FOUND, 1));
        add_row(mk_row(ACT_STEP, '0, 1, ST_STEP, 1, 0, 0, 1));
        add_row(mk_row(ACT_STEP, '0));
        add_row(mk_row(ACT_SRCH, pack_in(0, 0, 0, 63, 63, 63, 63), 1, ST_FOUND, 1));
        add_row(mk_row(ACT_STEP, '1, 1, ST_STEP, 1, 63, 63, 1));
        add_row(mk_row(ACT_MAP, pack_in(0, 1, 1, 0, 0, 0, 0)));
        add_row(mk_row(ACT_MAP, pack_in(1, 0, 1, 0, 0, 0, 0)));
        add_row(mk_row(ACT_MAP, pack_in(1, 1, 1, 0, 0, 0, 0)));
        // start sealed in by obstacles
        add_row(mk_row(ACT_SRCH, pack_in(0, 0, 0, 0, 0, 2, 2), 1, ST_NOPATH, 0));
        // blocked start equal to goal
        add_row(mk_row(ACT_SRCH, pack_in(0, 0, 0, 1, 1, 1, 1), 1, ST_FOUND, 1));
        // blocked start still searched from
        add_row(mk_row(ACT_SRCH, pack_in(0, 0, 0, 1, 1, 3, 4)));
        repeat (4) add_row(mk_row(ACT_STEP, '0));
        add_row(mk_row(ACT_MAP, pack_in(63, 63, 1, 63, 63, 63, 63)));
        add_row(mk_row(ACT_MAP, pack_in(63, 63, 0, 0, 0, 0, 0)));
        add_row(mk_row(ACT_MAP, pack_in(1, 1, 0, 0, 0, 0, 0)));
        add_row(mk_row(ACT_NONE, pack_in(63, 63, 1, 63, 63, 63, 63)));
        add_row(mk_row(ACT_SRCH, pack_in(0, 0, 0, 0, 0, 4, 6)));
        repeat (4) add_row(mk_row(ACT_STEP, '0));
        foreach (drill[i])
            put_word(drill[i].act, drill[i].data, drill[i].fixed, drill[i].want);

        // random phases over grid sizes, extremes included
        n_items = 0;
        rand_on = 1'b1;
        run_phase(4, 4, 9, -1);
        run_phase(1, 1, 4, -1);
        run_phase(0, 0, 3, -1);
        run_phase(8, 8, 9, 5);
        run_phase(3, 16, 8, -1);
        run_phase(127, 127, 3, -1);
        run_phase(16, 5, 8, -1);
        run_phase(12, 12, 8, -1);
        run_phase(64, 1, 4, -1);
        run_phase(2, 64, 6, -1);
        run_phase(6, 10, 9, -1);
        run_phase(64, 64, 3, -1);
        run_phase(10, 7, 9, -1);

        i_s_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("covered %0d random words, %0d register writes, grids 1x1 to 64x64",
                 n_items, n_cfg);
        $display("searches: %0d found, %0d no path, %0d overflow; %0d path steps read",
                 n_found, n_nopath, n_ovfl, n_steps);
        if (n_err == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/gasp_pkg.sv
rtl/core/gasp_octile.sv
rtl/core/grid_astar_path_search.sv
sim/tb_grid_astar_path_search.sv
